// ----- design/sfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, codes and constants of the sensor frame check and convert unit.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  // Measurement kind codes. Code 3 is unused and is handled as a temperature
  // read that carries a check byte.
  typedef enum logic [1:0] {
    FUNC_HUM        = 2'd0,
    FUNC_TEMP       = 2'd1,
    FUNC_TEMP_NOCHK = 2'd2
  } func_e;

  localparam int unsigned RawW   = 16;
  localparam int unsigned CrcW   = 8;
  localparam int unsigned MulW   = 15;
  localparam int unsigned ValueW = 15;

  localparam logic [CrcW-1:0] CrcPoly = 8'h31;

  // Humidity flips bit 1 of the raw word before scaling
  localparam logic [RawW-1:0] HumFlip = 16'h0002;

  // Fixed-point scale factors (value = floor(raw * mul / 2^16) - ofs)
  localparam logic [MulW-1:0] HumMul  = 15'd12498;
  localparam logic [MulW-1:0] TempMul = 15'd17570;
  localparam logic signed [ValueW:0] HumOfs  = 16'sd600;
  localparam logic signed [ValueW:0] TempOfs = 16'sd4685;
  localparam logic signed [ValueW:0] HumMax  = 16'sd10000;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] raw_high;
    logic [7:0] raw_low;
    logic [7:0] check_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_centi;
    logic                     crc_error;
  } out_item_t;

  // CRC-8 remainder of a 16-bit word holding a single one at position pos.
  // The CRC is linear, so the remainder of any word is the xor of these.
  // Only ever called with constant arguments.
  function automatic logic [CrcW-1:0] crc_column(input int unsigned pos);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = '0;
    for (int i = RawW - 1; i >= 0; i--) begin
      fb  = crc[CrcW-1] ^ (pos == unsigned'(i));
      crc = {crc[CrcW-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

// ----- design/sfcc_crc_check.sv -----
// ----------------------------------------------------------------------------
// sfcc_crc_check
// CRC-8 (poly 0x31, zero init) over the raw word, compared with the check byte.
// ----------------------------------------------------------------------------
module sfcc_crc_check (
  input  logic [1:0]  func_i,
  input  logic [15:0] raw_i,
  input  logic [7:0]  check_byte_i,
  output logic        crc_error_o
);

  logic [7:0] crc;

  // xor of per-bit columns: a flat parity tree per output bit
  always_comb begin
    crc = '0;
    for (int i = 0; i < 16; i++) begin
      if (raw_i[i]) begin
        crc = crc ^ sfcc_pkg::crc_column(unsigned'(i));
      end
    end
  end

  // no check byte follows a temperature read done after humidity
  assign crc_error_o = (func_i != sfcc_pkg::FUNC_TEMP_NOCHK) && (crc != check_byte_i);

endmodule

// ----- design/sfcc_convert.sv -----
// ----------------------------------------------------------------------------
// sfcc_convert
// Raw word to hundredths of percent (humidity) or of a degree (temperature).
// ----------------------------------------------------------------------------
module sfcc_convert (
  input  logic [1:0]         func_i,
  input  logic [15:0]        raw_i,
  output logic signed [14:0] value_o
);

  logic              is_hum;
  logic [15:0]       raw_adj;
  logic [14:0]       mul;
  logic [30:0]       prod;
  logic signed [15:0] ofs;
  logic signed [15:0] diff;

  assign is_hum  = (func_i == sfcc_pkg::FUNC_HUM);
  assign raw_adj = is_hum ? (raw_i ^ sfcc_pkg::HumFlip) : raw_i;
  assign mul     = is_hum ? sfcc_pkg::HumMul : sfcc_pkg::TempMul;
  assign ofs     = is_hum ? sfcc_pkg::HumOfs : sfcc_pkg::TempOfs;
  assign prod    = 31'(raw_adj) * 31'(mul);
  assign diff    = $signed({1'b0, prod[30:16]}) - ofs;

  always_comb begin
    value_o = diff[14:0];
    if (is_hum) begin
      if (diff < 16'sd0) begin
        value_o = '0;
      end else if (diff > sfcc_pkg::HumMax) begin
        value_o = sfcc_pkg::HumMax[14:0];
      end
    end
  end

endmodule

// ----- design/sensor_frame_crc_convert_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_unit
// Checks the CRC-8 of one sensor answer frame and converts its raw reading.
// ----------------------------------------------------------------------------
// Each input transfer carries one frame (kind code, two raw bytes, check
// byte) and yields exactly one result transfer: a signed value in hundredths
// and a CRC error flag. The unit accepts a frame every cycle unless in_stall_o
// is high, which only happens while the output is full and stalled. The
// path is an input register, then the CRC parity tree and one 16x15 constant
// multiply with offset and clamp, then the result register. A frame whose CRC
// does not match gives value 0 with crc_error set; temperature read after a
// humidity measurement (kind 2) carries no check byte and never flags an
// error; kind 3 is handled as temperature with a check byte. Humidity is
// clamped to 0..10000. There is no state beyond the two pipeline registers,
// so reset only empties the pipeline.
// ----------------------------------------------------------------------------
module sensor_frame_crc_convert_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfcc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfcc_pkg::out_item_t out_data_o
);

  // input register stage
  logic                in_valid_q;
  sfcc_pkg::in_item_t  in_q;
  // result register stage
  logic                out_valid_q;
  sfcc_pkg::out_item_t out_q;
  sfcc_pkg::out_item_t out_d;

  logic               out_ready;   // result register can take a new item
  logic               in_ready;    // input register can take a new item
  logic [15:0]        raw;
  logic               crc_error;
  logic signed [14:0] value;

  // Classic stall chain: each stage moves when it is empty or its content
  // moves on in the same cycle.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  assign raw = {in_q.raw_high, in_q.raw_low};

  sfcc_crc_check u_crc (
    .func_i       (in_q.func),
    .raw_i        (raw),
    .check_byte_i (in_q.check_byte),
    .crc_error_o  (crc_error)
  );

  sfcc_convert u_conv (
    .func_i  (in_q.func),
    .raw_i   (raw),
    .value_o (value)
  );

  // a failed check forces the value to zero
  always_comb begin
    out_d.crc_error   = crc_error;
    out_d.value_centi = crc_error ? '0 : value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (out_ready && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/sfcc_checker.sv -----
// ----------------------------------------------------------------------------
// sfcc_checker
// Port-level assertions for the sensor frame check and convert unit.
// ----------------------------------------------------------------------------
module sfcc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sfcc_pkg::out_item_t out_data_o,
  input logic                out_valid_o,
  input logic                out_stall_i
);

  // a held result must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // an accepted frame reaches the output through the input and result registers when unstalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after accepted frame");

  // a CRC error always reports value zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crc_error |-> out_data_o.value_centi == '0)
    else $error("nonzero value with crc error");

  // converted values stay within the sensor range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.crc_error |->
      ($signed(out_data_o.value_centi) >= -15'sd4685) &&
      ($signed(out_data_o.value_centi) <= 15'sd12884))
    else $error("value out of range");

endmodule

bind sensor_frame_crc_convert_unit sfcc_checker u_sfcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
